// ----- rtl/distance_gain_attenuation_core_defines.svh -----
// assertion macros for the distance gain attenuation core
// used by distance_gain_attenuation_core.sv, no other dependencies
`ifndef DISTANCE_GAIN_ATTENUATION_CORE_DEFINES_SVH
`define DISTANCE_GAIN_ATTENUATION_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define DGA_ASSERT_NOW(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("dga assertion failed");

// condition implies consequence in the next cycle
`define DGA_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("dga assertion failed");

`endif

// ----- rtl/dga_pkg.sv -----
// types, constants and elaboration-time helpers for the attenuation core
// no dependencies
package dga_pkg;

  localparam int COORD_W = 24;
  localparam int GAIN_F  = 16;
  localparam int GAIN_W  = GAIN_F + 1;
  localparam int RAD_W   = 24;
  localparam int ROLL_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [GAIN_W-1:0] GAIN_ONE    = GAIN_W'(1) << GAIN_F;
  localparam logic [ROLL_W-1:0] ROLLOFF_MIN = ROLL_W'(26);

  localparam logic [CFG_IDX_W-1:0] REG_INNER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROLLOFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POS     = 3'd5;

  localparam logic [1:0] KIND_UNITY = 2'd0;
  localparam logic [1:0] KIND_ZERO  = 2'd1;
  localparam logic [1:0] KIND_CALC  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] listener_x;
    logic signed [COORD_W-1:0] listener_y;
    logic signed [COORD_W-1:0] listener_z;
    logic signed [COORD_W-1:0] source_x;
    logic signed [COORD_W-1:0] source_y;
    logic signed [COORD_W-1:0] source_z;
  } in_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] attenuation;
    logic [GAIN_W-1:0] effective_gain;
  } out_item_t;

  // 2^(-2^-k) in Q0.32, each the floor square root of the previous one
  function automatic logic [31:0] exp_const(input int k);
    logic [63:0] c;
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] trial;
    int j;
    int i;
    c = 64'd1 << 31;
    for (j = 1; j <= k; j++) begin
      x = c << 32;
      res = 64'd0;
      for (i = 31; i >= 0; i--) begin
        trial = res | (64'd1 << i);
        if (trial * trial <= x) begin
          res = trial;
        end
      end
      c = res;
    end
    return c[31:0];
  endfunction

endpackage

// ----- rtl/distance_gain_attenuation_core.sv -----
// distance attenuation and gain pipeline, top level
// depends on dga_pkg and distance_gain_attenuation_core_defines.svh
// usage:
//   item channel: item_valid/item_stall with item (listener and source position,
//   signed Q16.8). result channel: result_valid/result_stall with result
//   (attenuation and effective gain, Q1.16).
//   an item is taken at a clock edge with valid high and stall low.
//   configuration: cfg_write, cfg_index, cfg_data; write only while idle.
//   depth: 81 register stages from the item input to result_valid.
//   throughput: one item per cycle while no waiting result is stalled; every stage is
//   a register, the distance square root (25 stages), the falloff divider (16) and the
//   log squarings (16) take one result bit per stage, the exp2 multiplies (16) one exponent bit.
//   when result_stall holds a waiting result, the whole pipeline freezes and
//   item_stall rises; nothing is dropped or repeated.
//   reset (rst, synchronous) empties the pipeline and loads the register
//   defaults: inner 1.0, outer 50.0, rolloff 2.0, unity volumes, not positional.
`include "distance_gain_attenuation_core_defines.svh"

module distance_gain_attenuation_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  dga_pkg::in_item_t                     item,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output dga_pkg::out_item_t                    result,
  input  logic                                  cfg_write,
  input  logic [dga_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dga_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int SQ_N = 25;
  localparam int DV_N = 16;
  localparam int LG_N = 16;
  localparam int EX_N = 16;

  logic adv;

  logic [23:0] inner_rad;
  logic [23:0] outer_rad;
  logic [11:0] rolloff_exponent;
  logic [16:0] channel_volume;
  logic [16:0] master_volume;
  logic        positional_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_rad        <= 24'd256;
      outer_rad        <= 24'd12800;
      rolloff_exponent <= 12'd512;
      channel_volume   <= dga_pkg::GAIN_ONE;
      master_volume    <= dga_pkg::GAIN_ONE;
      positional_mode  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dga_pkg::REG_INNER:   inner_rad        <= cfg_data[23:0];
        dga_pkg::REG_OUTER:   outer_rad        <= cfg_data[23:0];
        dga_pkg::REG_ROLLOFF: rolloff_exponent <= cfg_data[11:0];
        dga_pkg::REG_CHANNEL: channel_volume   <= cfg_data[16:0];
        dga_pkg::REG_MASTER:  master_volume    <= cfg_data[16:0];
        dga_pkg::REG_POS:     positional_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;

  // coordinate differences
  logic        df_v;
  logic [23:0] df_x, df_y, df_z;
  logic signed [24:0] ex_dx, ex_dy, ex_dz;

  assign ex_dx = 25'(item.source_x) - 25'(item.listener_x);
  assign ex_dy = 25'(item.source_y) - 25'(item.listener_y);
  assign ex_dz = 25'(item.source_z) - 25'(item.listener_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      df_v <= 1'b0;
    end else if (adv) begin
      df_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      df_x <= ex_dx[24] ? 24'(-ex_dx) : ex_dx[23:0];
      df_y <= ex_dy[24] ? 24'(-ex_dy) : ex_dy[23:0];
      df_z <= ex_dz[24] ? 24'(-ex_dz) : ex_dz[23:0];
    end
  end

  // squares
  logic        sq2_v;
  logic [47:0] sq2_x, sq2_y, sq2_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq2_v <= 1'b0;
    end else if (adv) begin
      sq2_v <= df_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq2_x <= df_x * df_x;
      sq2_y <= df_y * df_y;
      sq2_z <= df_z * df_z;
    end
  end

  // sum of squares
  logic        sum_v;
  logic [49:0] sum_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_v <= 1'b0;
    end else if (adv) begin
      sum_v <= sq2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_q <= 50'(sq2_x) + 50'(sq2_y) + 50'(sq2_z);
    end
  end

  // square root, one root bit per stage
  logic        sq_v    [SQ_N];
  logic [26:0] sq_rem  [SQ_N];
  logic [24:0] sq_root [SQ_N];
  logic [49:0] sq_x    [SQ_N];

  for (genvar s = 0; s < SQ_N; s++) begin : g_sqrt
    logic        v_in;
    logic [26:0] rem_in;
    logic [24:0] root_in;
    logic [49:0] x_in;
    logic [27:0] rem_sh;
    logic [27:0] trial;

    if (s == 0) begin : g_first
      assign v_in    = sum_v;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = sum_q;
    end else begin : g_next
      assign v_in    = sq_v[s-1];
      assign rem_in  = sq_rem[s-1];
      assign root_in = sq_root[s-1];
      assign x_in    = sq_x[s-1];
    end

    assign rem_sh = {rem_in[25:0], x_in[2*(SQ_N-1-s) +: 2]};
    assign trial  = {1'b0, root_in[24:0], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[s] <= 1'b0;
      end else if (adv) begin
        sq_v[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_x[s] <= x_in;
        if (rem_sh >= trial) begin
          sq_rem[s]  <= 27'(rem_sh - trial);
          sq_root[s] <= {root_in[23:0], 1'b1};
        end else begin
          sq_rem[s]  <= rem_sh[26:0];
          sq_root[s] <= {root_in[23:0], 1'b0};
        end
      end
    end
  end

  // radius classification
  logic        cl_v;
  logic [1:0]  cl_kind;
  logic [23:0] cl_num;
  logic [24:0] root_d;
  logic        degen;
  logic [23:0] den;

  assign root_d = sq_root[SQ_N-1];
  assign degen  = (outer_rad == 24'd0) || (outer_rad <= inner_rad);
  assign den    = outer_rad - inner_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      cl_v <= 1'b0;
    end else if (adv) begin
      cl_v <= sq_v[SQ_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cl_num <= outer_rad - root_d[23:0];
      if (degen || root_d <= {1'b0, inner_rad}) begin
        cl_kind <= dga_pkg::KIND_UNITY;
      end else if (root_d >= {1'b0, outer_rad}) begin
        cl_kind <= dga_pkg::KIND_ZERO;
      end else begin
        cl_kind <= dga_pkg::KIND_CALC;
      end
    end
  end

  // falloff division, one quotient bit per stage
  logic        dv_v    [DV_N];
  logic [1:0]  dv_kind [DV_N];
  logic [23:0] dv_rem  [DV_N];
  logic [15:0] dv_q    [DV_N];

  for (genvar s = 0; s < DV_N; s++) begin : g_div
    logic        v_in;
    logic [1:0]  kind_in;
    logic [23:0] rem_in;
    logic [15:0] q_in;
    logic [24:0] t;

    if (s == 0) begin : g_first
      assign v_in    = cl_v;
      assign kind_in = cl_kind;
      assign rem_in  = cl_num;
      assign q_in    = '0;
    end else begin : g_next
      assign v_in    = dv_v[s-1];
      assign kind_in = dv_kind[s-1];
      assign rem_in  = dv_rem[s-1];
      assign q_in    = dv_q[s-1];
    end

    assign t = {rem_in, 1'b0};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[s] <= 1'b0;
      end else if (adv) begin
        dv_v[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_kind[s] <= kind_in;
        if (t >= {1'b0, den}) begin
          dv_rem[s] <= 24'(t - {1'b0, den});
          dv_q[s]   <= {q_in[14:0], 1'b1};
        end else begin
          dv_rem[s] <= t[23:0];
          dv_q[s]   <= {q_in[14:0], 1'b0};
        end
      end
    end
  end

  // normalize falloff for the log
  logic        lo_v;
  logic [1:0]  lo_kind;
  logic [3:0]  lo_m;
  logic [30:0] lo_y;
  logic [15:0] fall;
  logic [3:0]  lead;

  assign fall = dv_q[DV_N-1];

  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (fall[i]) begin
        lead = 4'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_v <= 1'b0;
    end else if (adv) begin
      lo_v <= dv_v[DV_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_m <= lead;
      lo_y <= {15'd0, fall} << (5'd30 - {1'b0, lead});
      if (dv_kind[DV_N-1] == dga_pkg::KIND_CALC && fall == 16'd0) begin
        lo_kind <= dga_pkg::KIND_ZERO;
      end else begin
        lo_kind <= dv_kind[DV_N-1];
      end
    end
  end

  // log2 fraction bits by repeated squaring
  logic        lg_v    [LG_N];
  logic [1:0]  lg_kind [LG_N];
  logic [3:0]  lg_m    [LG_N];
  logic [30:0] lg_y    [LG_N];
  logic [15:0] lg_frac [LG_N];

  for (genvar s = 0; s < LG_N; s++) begin : g_log
    logic        v_in;
    logic [1:0]  kind_in;
    logic [3:0]  m_in;
    logic [30:0] y_in;
    logic [15:0] frac_in;
    logic [61:0] prod;
    logic [31:0] t;

    if (s == 0) begin : g_first
      assign v_in    = lo_v;
      assign kind_in = lo_kind;
      assign m_in    = lo_m;
      assign y_in    = lo_y;
      assign frac_in = '0;
    end else begin : g_next
      assign v_in    = lg_v[s-1];
      assign kind_in = lg_kind[s-1];
      assign m_in    = lg_m[s-1];
      assign y_in    = lg_y[s-1];
      assign frac_in = lg_frac[s-1];
    end

    assign prod = y_in * y_in;
    assign t    = prod[61:30];

    always_ff @(posedge clk) begin
      if (rst) begin
        lg_v[s] <= 1'b0;
      end else if (adv) begin
        lg_v[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        lg_kind[s] <= kind_in;
        lg_m[s]    <= m_in;
        lg_frac[s] <= {frac_in[14:0], t[31]};
        lg_y[s]    <= t[31] ? t[31:1] : t[30:0];
      end
    end
  end

  // scale by rolloff
  logic        ee_v;
  logic [1:0]  ee_kind;
  logic [24:0] ee_e;
  logic [20:0] nlog;
  logic [11:0] roll;
  logic [32:0] eprod;

  assign nlog  = {5'd16 - {1'b0, lg_m[LG_N-1]}, 16'd0} - {5'd0, lg_frac[LG_N-1]};
  assign roll  = (rolloff_exponent < dga_pkg::ROLLOFF_MIN) ? dga_pkg::ROLLOFF_MIN
                                                           : rolloff_exponent;
  assign eprod = roll * nlog;

  always_ff @(posedge clk) begin
    if (rst) begin
      ee_v <= 1'b0;
    end else if (adv) begin
      ee_v <= lg_v[LG_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ee_kind <= lg_kind[LG_N-1];
      ee_e    <= eprod[32:8];
    end
  end

  // exp2 of the fraction, one constant multiply per stage
  logic        ex_v    [EX_N];
  logic [1:0]  ex_kind [EX_N];
  logic [24:0] ex_e    [EX_N];
  logic [32:0] ex_acc  [EX_N];

  for (genvar s = 0; s < EX_N; s++) begin : g_exp
    localparam logic [31:0] C = dga_pkg::exp_const(s + 1);
    logic        v_in;
    logic [1:0]  kind_in;
    logic [24:0] e_in;
    logic [32:0] acc_in;
    logic [64:0] prod;

    if (s == 0) begin : g_first
      assign v_in    = ee_v;
      assign kind_in = ee_kind;
      assign e_in    = ee_e;
      assign acc_in  = 33'd1 << 32;
    end else begin : g_next
      assign v_in    = ex_v[s-1];
      assign kind_in = ex_kind[s-1];
      assign e_in    = ex_e[s-1];
      assign acc_in  = ex_acc[s-1];
    end

    assign prod = acc_in * C;

    always_ff @(posedge clk) begin
      if (rst) begin
        ex_v[s] <= 1'b0;
      end else if (adv) begin
        ex_v[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ex_kind[s] <= kind_in;
        ex_e[s]    <= e_in;
        ex_acc[s]  <= e_in[EX_N-1-s] ? prod[64:32] : acc_in;
      end
    end
  end

  // integer shift and attenuation select, base gain
  logic        at_v;
  logic [16:0] at_q;
  logic [16:0] at_g0;
  logic [9:0]  shamt;
  logic [32:0] shifted;
  logic [16:0] mv, cv;
  logic [33:0] gprod0;

  assign shamt   = 10'd16 + {1'b0, ex_e[EX_N-1][24:16]};
  assign shifted = (shamt >= 10'd33) ? 33'd0 : (ex_acc[EX_N-1] >> shamt);
  assign mv      = (master_volume > dga_pkg::GAIN_ONE) ? dga_pkg::GAIN_ONE : master_volume;
  assign cv      = (channel_volume > dga_pkg::GAIN_ONE) ? dga_pkg::GAIN_ONE : channel_volume;
  assign gprod0  = mv * cv;

  always_ff @(posedge clk) begin
    if (rst) begin
      at_v <= 1'b0;
    end else if (adv) begin
      at_v <= ex_v[EX_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      at_g0 <= gprod0[32:16];
      unique case (ex_kind[EX_N-1])
        dga_pkg::KIND_UNITY: at_q <= dga_pkg::GAIN_ONE;
        dga_pkg::KIND_CALC:  at_q <= shifted[16:0];
        default:             at_q <= 17'd0;
      endcase
    end
  end

  // output register
  logic [33:0] gprod1;

  assign gprod1 = at_g0 * at_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= at_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.attenuation    <= at_q;
      result.effective_gain <= positional_mode ? gprod1[32:16] : at_g0;
    end
  end

  `DGA_ASSERT_NOW(a_att_range, clk, rst, result_valid,
                  result.attenuation <= dga_pkg::GAIN_ONE)
  `DGA_ASSERT_NOW(a_pos_gain_le_att, clk, rst, result_valid && positional_mode,
                  result.effective_gain <= result.attenuation)
  `DGA_ASSERT_NOW(a_degen_unity, clk, rst, result_valid && degen,
                  result.attenuation == dga_pkg::GAIN_ONE)
  `DGA_ASSERT_NOW(a_log_norm, clk, rst, lo_v && lo_kind == dga_pkg::KIND_CALC,
                  lo_y[30])
  `DGA_ASSERT_NEXT(a_stall_freeze, clk, rst, cl_v && !adv, cl_v)

endmodule
